[rtl/core/cal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_pkg
// Shared types, constants and helpers for the connection admission limiter.
// ----------------------------------------------------------------------------
package cal_pkg;

    localparam int unsigned TENANTS_DEF = 64;
    localparam int unsigned USERS_DEF   = 1024;

    localparam int unsigned WINDOW_W = 36;
    localparam int unsigned TIME_W   = 48;
    localparam int unsigned LIMIT_W  = 20;
    localparam int unsigned TCOUNT_W = 21;
    localparam int unsigned UCOUNT_W = 20;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 36'd3600000000;
    localparam logic [TCOUNT_W-1:0] TCOUNT_MAX   = '1;
    localparam logic [UCOUNT_W-1:0] UCOUNT_MAX   = '1;

    typedef enum logic [2:0] {
        ADM_GRANTED    = 3'd0,
        ADM_HELD       = 3'd1,
        ADM_SKIPPED    = 3'd2,
        ADM_TENANT     = 3'd3,
        ADM_HOURLY     = 3'd4,
        ADM_CONCURRENT = 3'd5,
        ADM_RELEASED   = 3'd6,
        ADM_NOTHING    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic                kind;
        logic [5:0]          tenant_index;
        logic [9:0]          user_index;
        logic                is_super;
        logic                mysql_mode;
        logic                session_holds;
        logic [LIMIT_W-1:0]  hourly_limit;
        logic [LIMIT_W-1:0]  user_limit;
        logic [LIMIT_W-1:0]  tenant_limit;
        logic [TIME_W-1:0]   now_us;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic                holds_after;
        logic [TCOUNT_W-1:0] tenant_connections;
    } t_rsp;

    typedef struct packed {
        logic                valid;
        logic [TCOUNT_W-1:0] count;
    } t_tenant_entry;

    typedef struct packed {
        logic                valid;
        logic [UCOUNT_W-1:0] current;
        logic [UCOUNT_W-1:0] history;
        logic [TIME_W-1:0]   window_start;
    } t_user_entry;

    typedef struct packed {
        t_tenant_entry tenant;
        t_user_entry   user;
        t_rsp          rsp;
    } t_decision;

    // Remainder of a narrow index by a constant table depth, done as a
    // restoring compare-and-subtract; steps with an oversized shifted divisor
    // fold away at elaboration.
    function automatic logic [15:0] f_reduce(input logic [15:0] value,
                                             input int unsigned divisor);
        logic [31:0] rem;
        logic [31:0] step;
        rem = {16'b0, value};
        for (int k = 15; k >= 0; k--) begin
            step = 32'(divisor) << k;
            if (rem >= step) begin
                rem = rem - step;
            end
        end
        return rem[15:0];
    endfunction

endpackage
`default_nettype wire

[rtl/core/cal_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module cal_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 8,
    parameter int unsigned AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[rtl/core/cal_admit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_admit
// Admission decision: takes one request and the tenant and user entries read
// for it, and forms the entries to write back and the response word.
// ----------------------------------------------------------------------------
module cal_admit
    import cal_pkg::*;
(
    input  wire t_req                 i_req,
    input  wire t_tenant_entry        i_tenant,
    input  wire t_user_entry          i_user,
    input  wire logic [WINDOW_W-1:0]  i_window,
    output t_decision                 o_dec
);

    logic [TCOUNT_W-1:0] w_tlimit;
    logic [TIME_W-1:0]   w_age;
    logic                w_expired;
    logic                w_hourly_on;
    logic                w_ulimit_on;

    assign w_tlimit    = {1'b0, i_req.tenant_limit};
    assign w_hourly_on = (i_req.hourly_limit != '0);
    assign w_ulimit_on = (i_req.user_limit != '0);
    assign w_age       = i_req.now_us - i_user.window_start;
    assign w_expired   = w_hourly_on && (i_req.now_us > i_user.window_start) &&
                         (w_age > {{(TIME_W-WINDOW_W){1'b0}}, i_window});

    always_comb begin
        t_tenant_entry tn;
        t_user_entry   us;
        t_status       st;
        logic          hold;
        logic          tok;
        t_status       ures;

        tn   = i_tenant;
        us   = i_user;
        st   = ADM_GRANTED;
        hold = 1'b0;
        tok  = 1'b1;
        ures = ADM_GRANTED;

        if (!i_req.kind) begin
            if (i_req.session_holds) begin
                st   = ADM_HELD;
                hold = 1'b1;
            end else if (!i_req.mysql_mode) begin
                st = ADM_SKIPPED;
            end else begin
                // Tenant stage; a super user may take one slot past the limit.
                if (!i_tenant.valid) begin
                    tn.valid = 1'b1;
                    tn.count = TCOUNT_W'(1);
                end else if ((i_tenant.count < w_tlimit) ||
                             ((i_tenant.count == w_tlimit) && i_req.is_super)) begin
                    if (i_tenant.count != TCOUNT_MAX) begin
                        tn.count = i_tenant.count + TCOUNT_W'(1);
                    end
                end else begin
                    tok = 1'b0;
                end

                if (!tok) begin
                    st = ADM_TENANT;
                end else if (!w_hourly_on && !w_ulimit_on) begin
                    st   = ADM_GRANTED;
                    hold = 1'b1;
                end else begin
                    // User stage.
                    if (!i_user.valid) begin
                        us.valid        = 1'b1;
                        us.current      = UCOUNT_W'(w_ulimit_on);
                        us.history      = UCOUNT_W'(w_hourly_on);
                        us.window_start = w_hourly_on ? i_req.now_us : '0;
                    end else begin
                        if (w_expired) begin
                            us.window_start = i_req.now_us;
                            us.history      = '0;
                        end else if (w_hourly_on &&
                                     (i_user.history >= i_req.hourly_limit)) begin
                            ures = ADM_HOURLY;
                        end
                        if ((ures == ADM_GRANTED) && w_ulimit_on &&
                            (i_user.current >= i_req.user_limit)) begin
                            ures = ADM_CONCURRENT;
                        end
                        if (ures == ADM_GRANTED) begin
                            if (w_hourly_on && (us.history != UCOUNT_MAX)) begin
                                us.history = us.history + UCOUNT_W'(1);
                            end
                            if (w_ulimit_on && (us.current != UCOUNT_MAX)) begin
                                us.current = us.current + UCOUNT_W'(1);
                            end
                        end
                    end

                    if (ures != ADM_GRANTED) begin
                        // The user check failed, so the tenant slot goes back.
                        if (tn.count != '0) begin
                            tn.count = tn.count - TCOUNT_W'(1);
                        end
                        st = ures;
                    end else begin
                        st   = ADM_GRANTED;
                        hold = 1'b1;
                    end
                end
            end
        end else begin
            if (!i_req.session_holds) begin
                st = ADM_NOTHING;
            end else if (!i_req.mysql_mode) begin
                st   = ADM_SKIPPED;
                hold = 1'b1;
            end else begin
                if (i_tenant.valid && (i_tenant.count != '0)) begin
                    tn.count = i_tenant.count - TCOUNT_W'(1);
                end
                if (w_ulimit_on && i_user.valid && (i_user.current != '0)) begin
                    us.current = i_user.current - UCOUNT_W'(1);
                end
                st = ADM_RELEASED;
            end
        end

        o_dec.tenant                 = tn;
        o_dec.user                   = us;
        o_dec.rsp.status             = st;
        o_dec.rsp.holds_after        = hold;
        o_dec.rsp.tenant_connections = tn.valid ? tn.count : '0;
    end

endmodule
`default_nettype wire

[rtl/core/connection_admission_limiter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// connection_admission_limiter
// Admits or refuses connection requests against per-tenant and per-user
// limits, and releases slots on disconnect. Tenant and user entries live in
// two synchronous RAMs that are read, updated and written back per request.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                       Handshake
//  --------  --------------------------  -------------------------------------
//  request   i_word (t_req)              taken on an edge with start && !busy
//  result    o_word (t_rsp)              valid for one cycle while o_done
//  config    i_cfg_we, i_cfg_wdata       window length written when i_cfg_we
//
// For each request, the edge that accepts it also reads the
// tenant and user RAMs, and the following cycle evaluates the limits and
// writes both entries back while the result word is registered. The result
// shows on o_done in the next cycle, where a new request may already be
// accepted; while a request is evaluated, busy is high and none is taken.
// After reset a clearing pass zeroes both RAMs; busy stays high through it.
// Results cannot be held off by the receiver.
//
module connection_admission_limiter
    import cal_pkg::*;
#(
    parameter int unsigned TENANTS = TENANTS_DEF,
    parameter int unsigned USERS   = USERS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire t_req                i_word,
    output logic                     o_done,
    output t_rsp                     o_word,
    input  wire logic                i_cfg_we,
    input  wire logic [WINDOW_W-1:0] i_cfg_wdata
);

    // Address widths of the two tables, and the clearing pass length.
    localparam int unsigned TAW     = (TENANTS > 1) ? $clog2(TENANTS) : 1;
    localparam int unsigned UAW     = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int unsigned CLR_LEN = (TENANTS > USERS) ? TENANTS : USERS;
    localparam int unsigned CW      = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
    localparam int unsigned TW      = $bits(t_tenant_entry);
    localparam int unsigned UW      = $bits(t_user_entry);
    localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_clr;
    logic [CW-1:0]         n_clr;
    logic [WINDOW_W-1:0]   r_window;
    t_req                  r_req;
    logic [TAW-1:0]        r_tidx;
    logic [UAW-1:0]        r_uidx;
    logic                  r_done;
    t_rsp                  r_rsp;

    logic                  w_accept;
    logic                  w_clearing;
    logic                  w_exec;
    logic [15:0]           w_tred;
    logic [15:0]           w_ured;
    logic [TAW-1:0]        w_tidx;
    logic [UAW-1:0]        w_uidx;

    logic                  w_t_we;
    logic [TAW-1:0]        w_t_waddr;
    logic [TW-1:0]         w_t_wdata;
    logic [TW-1:0]         w_t_rdata;
    logic                  w_u_we;
    logic [UAW-1:0]        w_u_waddr;
    logic [UW-1:0]         w_u_wdata;
    logic [UW-1:0]         w_u_rdata;
    t_decision             w_dec;

    // Indexes beyond a table wrap around its depth.
    assign w_tred = f_reduce(16'(i_word.tenant_index), TENANTS);
    assign w_ured = f_reduce(16'(i_word.user_index), USERS);
    assign w_tidx = w_tred[TAW-1:0];
    assign w_uidx = w_ured[UAW-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + CW'(1);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        busy       = 1'b1;
        w_accept   = 1'b0;
        w_clearing = 1'b0;
        w_exec     = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_clearing = 1'b1;
            end
            S_IDLE: begin
                busy     = 1'b0;
                w_accept = start;
            end
            S_EXEC: begin
                w_exec = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_window <= WINDOW_RESET;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= w_exec;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    // Request and result words carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_word;
            r_tidx <= w_tidx;
            r_uidx <= w_uidx;
        end
        if (w_exec) begin
            r_rsp <= w_dec.rsp;
        end
    end

    // The clearing pass writes zero entries; otherwise the updated entries
    // are written back at the end of the evaluate cycle. The next read of the
    // same entry happens only on a later accept in idle, so no forwarding is needed.
    assign w_t_we    = w_clearing ? (32'(r_clr) < TENANTS) : w_exec;
    assign w_t_waddr = w_clearing ? TAW'(r_clr) : r_tidx;
    assign w_t_wdata = w_clearing ? '0 : TW'(w_dec.tenant);
    assign w_u_we    = w_clearing ? (32'(r_clr) < USERS) : w_exec;
    assign w_u_waddr = w_clearing ? UAW'(r_clr) : r_uidx;
    assign w_u_wdata = w_clearing ? '0 : UW'(w_dec.user);

    cal_ram #(
        .DEPTH (TENANTS),
        .WIDTH (TW),
        .AW    (TAW)
    ) u_tenant_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (w_t_waddr),
        .i_wdata (w_t_wdata),
        .i_re    (w_accept),
        .i_raddr (w_tidx),
        .o_rdata (w_t_rdata)
    );

    cal_ram #(
        .DEPTH (USERS),
        .WIDTH (UW),
        .AW    (UAW)
    ) u_user_ram (
        .i_clk   (i_clk),
        .i_we    (w_u_we),
        .i_waddr (w_u_waddr),
        .i_wdata (w_u_wdata),
        .i_re    (w_accept),
        .i_raddr (w_uidx),
        .o_rdata (w_u_rdata)
    );

    cal_admit u_admit (
        .i_req    (r_req),
        .i_tenant (t_tenant_entry'(w_t_rdata)),
        .i_user   (t_user_entry'(w_u_rdata)),
        .i_window (r_window),
        .o_dec    (w_dec)
    );

    assign o_done = r_done;
    assign o_word = r_rsp;

    // A result word follows only the evaluate cycle of a request.
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without an evaluated request");

    // Every evaluated request yields a result word in the next cycle.
    a_exec_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_done)
        else $error("evaluated request produced no result");

    // An accepted request blocks further requests for its evaluate cycle.
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted while another was in flight");

    // A granted connection always leaves its tenant with a live count.
    a_grant_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_word.status == ADM_GRANTED)) |-> (o_word.tenant_connections != '0))
        else $error("grant reported with an empty tenant count");

endmodule
`default_nettype wire
